### rtl/fdkcam_pkg.sv
package fdkcam_pkg;

   localparam int ENTRIES      = 16;
   localparam int UNIT_ID_BITS = 64;
   localparam int KEY_ID_BITS  = 64;
   localparam int ADDRESS_BITS = 64;

   localparam int PORT_BITS  = 64;
   localparam int SLOT_BITS  = $clog2(ENTRIES);
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CFG_BITS   = 5;
   localparam int WIDE_BITS  = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_ENTRIES_IN_USE = 0;
   localparam logic [CFG_BITS-1:0] ENTRIES_IN_USE_RESET = CFG_BITS'(16);

   localparam logic [1:0] OP_INSERT      = 2'd0;
   localparam logic [1:0] OP_LOOKUP_UNIT = 2'd1;
   localparam logic [1:0] OP_LOOKUP_KEY  = 2'd2;

   // one request travelling down the row of cells
   typedef struct packed {
      logic                    valid;
      logic [1:0]              op;
      logic [UNIT_ID_BITS-1:0] uid;
      logic [KEY_ID_BITS-1:0]  kid;
      logic [ADDRESS_BITS-1:0] addr;
      logic [SLOT_BITS-1:0]    slot;
      logic [COUNT_BITS-1:0]   scan_n;
      logic                    hit;
      logic [ADDRESS_BITS-1:0] found;
   } token_type;

endpackage

### rtl/fdkcam_cell.sv
module fdkcam_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic [fdkcam_pkg::SLOT_BITS-1:0]      cell_index,
   input  fdkcam_pkg::token_type                 prev_tok,
   output fdkcam_pkg::token_type                 next_tok
);

   logic [fdkcam_pkg::UNIT_ID_BITS-1:0] uid_ff;
   logic [fdkcam_pkg::KEY_ID_BITS-1:0]  kid_ff;
   logic [fdkcam_pkg::ADDRESS_BITS-1:0] addr_ff;
   fdkcam_pkg::token_type               tok_ff;
   fdkcam_pkg::token_type               tok_in;

   logic is_lookup;
   logic in_range;
   logic match;
   logic write_en;

   assign is_lookup = (prev_tok.op == fdkcam_pkg::OP_LOOKUP_UNIT) ||
                      (prev_tok.op == fdkcam_pkg::OP_LOOKUP_KEY);
   // only slots below the fill count at entry hold data
   assign in_range  = fdkcam_pkg::COUNT_BITS'(cell_index) < prev_tok.scan_n;
   assign match     = (prev_tok.op == fdkcam_pkg::OP_LOOKUP_UNIT) ?
                      (uid_ff == prev_tok.uid) : (kid_ff == prev_tok.kid);
   assign write_en  = advance && prev_tok.valid &&
                      (prev_tok.op == fdkcam_pkg::OP_INSERT) &&
                      (prev_tok.slot == cell_index);

   always_comb begin
      tok_in = prev_tok;
      // first match in index order wins: later cells see hit already set
      if (is_lookup && !prev_tok.hit && in_range && match) begin
         tok_in.hit   = 1'b1;
         tok_in.found = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         uid_ff  <= prev_tok.uid;
         kid_ff  <= prev_tok.kid;
         addr_ff <= prev_tok.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

### rtl/fifo_replace_dual_key_cam_top.sv
// A request accepted into the first cell is registered in each of the 16 table cells in turn
// and shows on rsp_ from the last of them; the whole row holds while that result waits.
// Throughput: one request per cycle while the row is not held; each of the 16 cells holds
// one table slot and passes the request on at each advance, so the row forms the pipeline.
// Reset: clears fill count, last slot and the pipeline valids, and sets entries_in_use
// to 16. Slot contents are not cleared; slots above the fill count are never matched.
module fifo_replace_dual_key_cam_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_opcode,
   input  logic [fdkcam_pkg::PORT_BITS-1:0]       req_unit_id,
   input  logic [fdkcam_pkg::PORT_BITS-1:0]       req_key_id,
   input  logic [fdkcam_pkg::PORT_BITS-1:0]       req_net_address,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic [fdkcam_pkg::PORT_BITS-1:0]       rsp_found_address,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [fdkcam_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [fdkcam_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [fdkcam_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                   pready
);

   localparam logic [fdkcam_pkg::CSR_ADDR_BITS-1:0] ADDR_ENTRIES_IN_USE =
      fdkcam_pkg::CSR_ADDR_BITS'(4 * fdkcam_pkg::REG_ENTRIES_IN_USE);

   logic [fdkcam_pkg::CFG_BITS-1:0]   entries_in_use_ff;
   logic [fdkcam_pkg::COUNT_BITS-1:0] fill_count_ff;
   logic [fdkcam_pkg::COUNT_BITS-1:0] fill_count_in;
   logic [fdkcam_pkg::SLOT_BITS-1:0]  last_slot_ff;
   logic [fdkcam_pkg::SLOT_BITS-1:0]  last_slot_in;

   logic [fdkcam_pkg::WIDE_BITS-1:0]  cfg_wide;
   logic [fdkcam_pkg::WIDE_BITS-1:0]  lim_wide;
   logic [fdkcam_pkg::COUNT_BITS-1:0] limit;
   logic [fdkcam_pkg::COUNT_BITS-1:0] next_after_last;
   logic [fdkcam_pkg::SLOT_BITS-1:0]  slot;
   logic                              table_full;
   logic                              advance;
   logic                              accept_insert;
   logic                              csr_write;

   fdkcam_pkg::token_type entry_tok;
   fdkcam_pkg::token_type chain [fdkcam_pkg::ENTRIES];

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == ADDR_ENTRIES_IN_USE);
   assign prdata    = (paddr == ADDR_ENTRIES_IN_USE) ?
                      fdkcam_pkg::CSR_DATA_BITS'(entries_in_use_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= fdkcam_pkg::ENTRIES_IN_USE_RESET;
      end else if (csr_write) begin
         entries_in_use_ff <= pwdata[fdkcam_pkg::CFG_BITS-1:0];
      end
   end

   // clamp the limit to 1..ENTRIES
   always_comb begin
      cfg_wide = fdkcam_pkg::WIDE_BITS'(entries_in_use_ff);
      if (cfg_wide == '0) begin
         lim_wide = fdkcam_pkg::WIDE_BITS'(1);
      end else if (cfg_wide > fdkcam_pkg::WIDE_BITS'(fdkcam_pkg::ENTRIES)) begin
         lim_wide = fdkcam_pkg::WIDE_BITS'(fdkcam_pkg::ENTRIES);
      end else begin
         lim_wide = cfg_wide;
      end
      limit = fdkcam_pkg::COUNT_BITS'(lim_wide);
   end

   // slot choice: fill in order, then replace the slot after the last one written
   assign table_full      = fill_count_ff >= limit;
   assign next_after_last = fdkcam_pkg::COUNT_BITS'(last_slot_ff) + fdkcam_pkg::COUNT_BITS'(1);

   always_comb begin
      if (table_full) begin
         slot = (next_after_last >= limit) ? '0 :
                next_after_last[fdkcam_pkg::SLOT_BITS-1:0];
      end else begin
         slot = fill_count_ff[fdkcam_pkg::SLOT_BITS-1:0];
      end
   end

   // the whole row moves together; hold while the last cell's result waits
   assign advance       = !chain[fdkcam_pkg::ENTRIES-1].valid || rsp_ready;
   assign req_ready     = advance;
   assign accept_insert = req_valid && req_ready && (req_opcode == fdkcam_pkg::OP_INSERT);

   always_comb begin
      fill_count_in = fill_count_ff;
      last_slot_in  = last_slot_ff;
      if (accept_insert) begin
         last_slot_in = slot;
         if (!table_full) begin
            fill_count_in = fill_count_ff + fdkcam_pkg::COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         last_slot_ff  <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
         last_slot_ff  <= last_slot_in;
      end
   end

   always_comb begin
      entry_tok.valid  = req_valid;
      entry_tok.op     = req_opcode;
      entry_tok.uid    = req_unit_id[fdkcam_pkg::UNIT_ID_BITS-1:0];
      entry_tok.kid    = req_key_id[fdkcam_pkg::KEY_ID_BITS-1:0];
      entry_tok.addr   = req_net_address[fdkcam_pkg::ADDRESS_BITS-1:0];
      entry_tok.slot   = slot;
      entry_tok.scan_n = fill_count_ff;
      entry_tok.hit    = (req_opcode == fdkcam_pkg::OP_INSERT);
      entry_tok.found  = '0;
   end

   for (genvar i = 0; i < fdkcam_pkg::ENTRIES; i++) begin : g_cell
      fdkcam_pkg::token_type prev_tok;
      if (i == 0) begin : g_first
         assign prev_tok = entry_tok;
      end else begin : g_rest
         assign prev_tok = chain[i-1];
      end
      fdkcam_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (fdkcam_pkg::SLOT_BITS'(i)),
         .prev_tok   (prev_tok),
         .next_tok   (chain[i])
      );
   end

   assign rsp_valid         = chain[fdkcam_pkg::ENTRIES-1].valid;
   assign rsp_hit           = chain[fdkcam_pkg::ENTRIES-1].hit;
   assign rsp_found_address = fdkcam_pkg::PORT_BITS'(chain[fdkcam_pkg::ENTRIES-1].found);

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= fdkcam_pkg::COUNT_BITS'(fdkcam_pkg::ENTRIES))
      else $error("fill count beyond table size");

   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill_count_ff >= $past(fill_count_ff))
      else $error("fill count decreased");

   a_insert_fills: assert property (@(posedge clock) disable iff (reset)
      accept_insert && !table_full |=> fill_count_ff == $past(fill_count_ff) +
                                       fdkcam_pkg::COUNT_BITS'(1))
      else $error("insert into free slot did not advance fill count");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_found_address == '0)
      else $error("miss carries a non-zero address");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

### sim/fifo_replace_dual_key_cam_top_tb.sv
module fifo_replace_dual_key_cam_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         LATENCY     = fdkcam_pkg::ENTRIES;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PHASES      = 10;
   localparam int         PHASE_ITEMS = 173;
   localparam logic [fdkcam_pkg::CSR_ADDR_BITS-1:0] ADDR_ENTRIES_IN_USE =
      fdkcam_pkg::CSR_ADDR_BITS'(4 * fdkcam_pkg::REG_ENTRIES_IN_USE);

   typedef struct packed {
      logic [1:0]                       op;
      logic [fdkcam_pkg::PORT_BITS-1:0] uid;
      logic [fdkcam_pkg::PORT_BITS-1:0] kid;
      logic [fdkcam_pkg::PORT_BITS-1:0] addr;
   } request_type;

   typedef struct packed {
      logic                             hit;
      logic [fdkcam_pkg::PORT_BITS-1:0] found;
   } answer_type;

   logic                                 clock;
   logic                                 reset           = 1'b1;
   logic                                 req_valid       = 1'b0;
   logic                                 req_ready;
   logic [1:0]                           req_opcode      = fdkcam_pkg::OP_INSERT;
   logic [fdkcam_pkg::PORT_BITS-1:0]     req_unit_id     = '0;
   logic [fdkcam_pkg::PORT_BITS-1:0]     req_key_id      = '0;
   logic [fdkcam_pkg::PORT_BITS-1:0]     req_net_address = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready       = 1'b0;
   logic                                 rsp_hit;
   logic [fdkcam_pkg::PORT_BITS-1:0]     rsp_found_address;
   logic                                 psel            = 1'b0;
   logic                                 penable         = 1'b0;
   logic                                 pwrite          = 1'b0;
   logic [fdkcam_pkg::CSR_ADDR_BITS-1:0] paddr           = '0;
   logic [fdkcam_pkg::CSR_DATA_BITS-1:0] pwdata          = '0;
   logic [fdkcam_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                                 pready;

   fifo_replace_dual_key_cam_top u_top (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // predicted table contents
   logic [fdkcam_pkg::CFG_BITS-1:0]     limit_reg = fdkcam_pkg::ENTRIES_IN_USE_RESET;
   int unsigned                         table_fill = 0;
   int unsigned                         table_last = 0;
   logic [fdkcam_pkg::UNIT_ID_BITS-1:0] unit_ids [fdkcam_pkg::ENTRIES];
   logic [fdkcam_pkg::KEY_ID_BITS-1:0]  key_ids  [fdkcam_pkg::ENTRIES];
   logic [fdkcam_pkg::ADDRESS_BITS-1:0] addrs    [fdkcam_pkg::ENTRIES];

   request_type                      request_queue[$];
   answer_type                       pending_answers[$];
   logic [fdkcam_pkg::PORT_BITS-1:0] unit_pool[$];
   logic [fdkcam_pkg::PORT_BITS-1:0] key_pool[$];

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   int unsigned gap_odds       = 0;
   int unsigned stall_odds     = 0;
   int unsigned gap_left       = 0;
   int unsigned stall_left     = 0;
   logic        req_taken      = 1'b0;
   request_type staged;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic answer_type resolve_request(
         input logic [1:0]                       op,
         input logic [fdkcam_pkg::PORT_BITS-1:0] uid,
         input logic [fdkcam_pkg::PORT_BITS-1:0] kid,
         input logic [fdkcam_pkg::PORT_BITS-1:0] addr);
      answer_type  a;
      int unsigned lim;
      int unsigned slot;
      int unsigned scan;
      int unsigned i;
      a = '0;
      lim = (limit_reg == 0) ? 1 :
            ((limit_reg > fdkcam_pkg::ENTRIES) ? fdkcam_pkg::ENTRIES : limit_reg);
      case (op)
         fdkcam_pkg::OP_INSERT: begin
            if (table_fill >= lim) begin
               // replacement: advance past the slot written last, wrap at the limit
               slot = table_last + 1;
               if (slot >= lim)
                  slot = 0;
            end else begin
               slot = table_fill;
               table_fill++;
            end
            if (slot >= fdkcam_pkg::ENTRIES)
               slot = 0;
            table_last     = slot;
            unit_ids[slot] = uid[fdkcam_pkg::UNIT_ID_BITS-1:0];
            key_ids[slot]  = kid[fdkcam_pkg::KEY_ID_BITS-1:0];
            addrs[slot]    = addr[fdkcam_pkg::ADDRESS_BITS-1:0];
            a.hit = 1'b1;
         end
         fdkcam_pkg::OP_LOOKUP_UNIT, fdkcam_pkg::OP_LOOKUP_KEY: begin
            scan = (table_fill > fdkcam_pkg::ENTRIES) ? fdkcam_pkg::ENTRIES : table_fill;
            for (i = 0; i < scan; i++) begin
               if (!a.hit && ((op == fdkcam_pkg::OP_LOOKUP_UNIT) ?
                      (unit_ids[i] == uid[fdkcam_pkg::UNIT_ID_BITS-1:0]) :
                      (key_ids[i] == kid[fdkcam_pkg::KEY_ID_BITS-1:0]))) begin
                  a.hit   = 1'b1;
                  a.found = fdkcam_pkg::PORT_BITS'(addrs[i]);
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [fdkcam_pkg::PORT_BITS-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return fdkcam_pkg::PORT_BITS'($urandom_range(0, 7));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [fdkcam_pkg::PORT_BITS-1:0] recall_id(
         input logic [fdkcam_pkg::PORT_BITS-1:0] pool[$]);
      if (pool.size() == 0 || $urandom_range(0, 3) == 0)
         return random_word();
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   function automatic request_type make_request();
      request_type r;
      int unsigned pick;
      pick   = $urandom_range(0, 99);
      r.uid  = recall_id(unit_pool);
      r.kid  = recall_id(key_pool);
      r.addr = random_word();
      if (pick < 40) begin
         r.op = fdkcam_pkg::OP_INSERT;
         unit_pool.push_back(r.uid);
         key_pool.push_back(r.kid);
         if (unit_pool.size() > 32) begin
            void'(unit_pool.pop_front());
            void'(key_pool.pop_front());
         end
      end else if (pick < 68) begin
         r.op = fdkcam_pkg::OP_LOOKUP_UNIT;
      end else if (pick < 95) begin
         r.op = fdkcam_pkg::OP_LOOKUP_KEY;
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic queue_request(input logic [1:0] op,
                                input logic [fdkcam_pkg::PORT_BITS-1:0] uid,
                                input logic [fdkcam_pkg::PORT_BITS-1:0] kid,
                                input logic [fdkcam_pkg::PORT_BITS-1:0] addr);
      request_queue.push_back('{op, uid, kid, addr});
   endtask

   task automatic set_entries_in_use(input logic [fdkcam_pkg::CFG_BITS-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_ENTRIES_IN_USE;
      pwdata  = fdkcam_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      limit_reg = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== fdkcam_pkg::CSR_DATA_BITS'(value))
         report_mismatch($sformatf("entries_in_use read %0h, expected %0h", prdata, value));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic drain();
      while (request_queue.size() != 0 || req_valid || pending_answers.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (req_valid && !req_taken) begin
         // hold until transfer
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (request_queue.size() != 0 && gap_odds != 0
                   && $urandom_range(0, 15) < gap_odds) begin
         req_valid <= 1'b0;
         gap_left  <= $urandom_range(0, 8);
      end else if (request_queue.size() != 0) begin
         staged = request_queue.pop_front();
         req_valid       <= 1'b1;
         req_opcode      <= staged.op;
         req_unit_id     <= staged.uid;
         req_key_id      <= staged.kid;
         req_net_address <= staged.addr;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check results first, then predict the new transfer
   always @(posedge clock) begin
      answer_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("result with nothing pending");
            end else begin
               want = pending_answers.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit %b, expected %b", rsp_hit, want.hit));
               if (rsp_found_address !== want.found)
                  report_mismatch($sformatf("found_address %h, expected %h",
                                            rsp_found_address, want.found));
            end
         end
         if (req_valid && req_ready)
            pending_answers.push_back(resolve_request(req_opcode, req_unit_id,
                                                      req_key_id, req_net_address));
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned limits[PHASES];
      int          p;
      int          n;
      limits = '{1, 16, 31, 17, 0, 2, $urandom_range(0, 31), $urandom_range(1, 16),
                 $urandom_range(3, 8), 16};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, absent IDs, duplicate unit IDs, unused opcode
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, '0, '0, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_KEY, '1, '1, '1);
      queue_request(OP_UNUSED, '1, '1, '1);
      queue_request(fdkcam_pkg::OP_INSERT, '0, '1, '1);
      queue_request(fdkcam_pkg::OP_INSERT, '1, '0, '0);
      queue_request(fdkcam_pkg::OP_INSERT, 64'd5, 64'd9, 64'h0123_4567_89ab_cdef);
      queue_request(fdkcam_pkg::OP_INSERT, 64'd5, 64'd10, 64'hfedc_ba98_7654_3210);
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, '0, '1, '1);
      queue_request(fdkcam_pkg::OP_LOOKUP_KEY, '1, '0, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, 64'd5, '0, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_KEY, '0, 64'd10, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, '1, '0, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_KEY, '0, '1, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, 64'd6, '0, '0);
      queue_request(OP_UNUSED, '0, '0, '0);
      drain();

      // limit lowered below the fill count
      set_entries_in_use(fdkcam_pkg::CFG_BITS'(2));
      queue_request(fdkcam_pkg::OP_INSERT, 64'd7, 64'd7, 64'haaaa_5555_aaaa_5555);
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, '0, '0, '0);
      queue_request(fdkcam_pkg::OP_LOOKUP_UNIT, 64'd5, '0, '0);
      queue_request(fdkcam_pkg::OP_INSERT, 64'd8, 64'd8, 64'h5555_aaaa_5555_aaaa);
      queue_request(fdkcam_pkg::OP_LOOKUP_KEY, '0, '0, '0);
      drain();

      // zero limit acts as one
      set_entries_in_use('0);
      queue_request(fdkcam_pkg::OP_INSERT, 64'd9, 64'd9, 64'h8000_0000_0000_0001);
      queue_request(fdkcam_pkg::OP_LOOKUP_KEY, '0, 64'd9, '0);
      drain();

      for (p = 0; p < PHASES; p++) begin
         set_entries_in_use(fdkcam_pkg::CFG_BITS'(limits[p]));
         // every third phase and the last one run without idling
         gap_odds   = (p % 3 == 2 || p == PHASES - 1) ? 0 : $urandom_range(1, 6);
         stall_odds = (p % 3 == 2 || p == PHASES - 1) ? 0 : $urandom_range(1, 6);
         for (n = 0; n < PHASE_ITEMS; n++)
            request_queue.push_back(make_request());
         drain();
      end

      repeat (LATENCY + 4) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### fifo_replace_dual_key_cam_top.f
rtl/fdkcam_pkg.sv
rtl/fdkcam_cell.sv
rtl/fifo_replace_dual_key_cam_top.sv
sim/fifo_replace_dual_key_cam_top_tb.sv
